// ===== rtl/kfc_pkg.sv =====
// ----------------------------------------------------------------------------
// kfc_pkg
// shared types and constants of the key frequency counter
// ----------------------------------------------------------------------------
package kfc_pkg;

    // field widths
    localparam int KEY_W   = 37;
    localparam int COUNT_W = 16;
    localparam int TIES_W  = 11;

    // stream widths, whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 64;

    // table geometry (buckets must be a power of two)
    localparam int BUCKETS   = 256;
    localparam int WAYS      = 4;
    localparam int SLOTS     = BUCKETS * WAYS;
    localparam int BUCKET_AW = $clog2(BUCKETS);
    localparam int WAY_AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int FILL_W    = $clog2(WAYS + 1);

    // hash: key mod 100000 = 32 * ((key >> 5) mod 3125) + key[4:0], with the
    // mod 3125 done by reciprocal multiplication and one correcting subtract
    localparam int     LOW_SHIFT  = 5;
    localparam int     ODD_MOD    = 3125;
    localparam int     HI_W       = KEY_W - LOW_SHIFT;
    localparam int     QUOT_SHIFT = 43;
    localparam int     QUOT_W     = 2 * HI_W - QUOT_SHIFT;
    localparam longint RECIP      = (longint'(1) << QUOT_SHIFT) / ODD_MOD;
    localparam int     ODD_W      = $clog2(2 * ODD_MOD);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [TIES_W-1:0]  TIES_MAX  = {TIES_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HASH,
        ST_FILL,
        ST_LOOK,
        ST_READ,
        ST_CMP,
        ST_UPDATE,
        ST_OUT
    } kfc_state_t;

    // one table access request per cycle
    typedef struct packed {
        logic                 rd_fill;
        logic                 wr_fill;
        logic                 rd_slot;
        logic                 wr_slot;
        logic [BUCKET_AW-1:0] bucket;
        logic [WAY_AW-1:0]    way;
        logic [FILL_W-1:0]    fill;
        logic [KEY_W-1:0]     key;
        logic [COUNT_W-1:0]   count;
    } kfc_tbl_req_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] count;
    } kfc_slot_t;

endpackage

// ===== rtl/key_frequency_counter_with_top_tracker.sv =====
// ----------------------------------------------------------------------------
// key_frequency_counter_with_top_tracker
// counts phone numbers in a set-associative table and tracks the top key
// ----------------------------------------------------------------------------
//
// channel   direction  tdata                                          tuser
// s_axis    in         phone_key[36:0]                                -
// m_axis    out        top_key[36:0] top_count[52:37] tie_total[63:53] dropped[0]
//
// each transaction runs the bucket hash for key mod 100000 (multiply, back
// multiply and subtract, correction, hand-over), then the single-port slot
// memory (one read then compare per way)
// s_tready is high only while idle; one transaction is in flight at a time
// a finished result sits in the output register while the next key comes in;
// a result still held there stalls the sequencer in its last step
// reset clears the tracker and the bucket valid flags at once; no clearing pass
//
module key_frequency_counter_with_top_tracker
(
    input  logic                              clk,
    input  logic                              rst_n,
    // phone_key[36:0]
    input  logic [kfc_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // top_key[36:0], top_count[52:37], tie_total[63:53]
    output logic [kfc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // dropped[0]
    output logic [0:0]                        m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready
);
    import kfc_pkg::*;

    kfc_state_t state_reg, state_next;

    logic [KEY_W-1:0]     key_reg,     key_next;
    logic [BUCKET_AW-1:0] bucket_reg,  bucket_next;
    logic [FILL_W-1:0]    fill_reg,    fill_next;
    logic [WAY_AW-1:0]    way_reg,     way_next;
    logic                 hit_reg,     hit_next;
    logic [COUNT_W-1:0]   cnt_reg,     cnt_next;
    logic                 dropped_reg, dropped_next;

    // top tracker
    logic [KEY_W-1:0]   best_key_reg,   best_key_next;
    logic [COUNT_W-1:0] best_count_reg, best_count_next;
    logic [TIES_W-1:0]  best_ties_reg,  best_ties_next;

    // output register
    logic                   out_valid_reg, out_valid_next;
    logic [OUT_TDATA_W-1:0] out_data_reg,  out_data_next;
    logic                   out_drop_reg,  out_drop_next;

    logic                 hash_start;
    logic                 hash_done;
    logic [BUCKET_AW-1:0] hash_bucket;

    kfc_tbl_req_t       tbl_req;
    logic [KEY_W-1:0]   tbl_key;
    logic [COUNT_W-1:0] tbl_count;
    logic [FILL_W-1:0]  tbl_fill;

    logic               track_en;
    logic [COUNT_W-1:0] track_count;

    kfc_hash u_hash
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start),
        .key    (s_tdata[KEY_W-1:0]),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    kfc_table u_table
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (tbl_req),
        .slot_key   (tbl_key),
        .slot_count (tbl_count),
        .fill       (tbl_fill)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        bucket_next    = bucket_reg;
        fill_next      = fill_reg;
        way_next       = way_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        dropped_next   = dropped_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_drop_next  = out_drop_reg;
        hash_start     = 1'b0;
        s_tready       = 1'b0;
        track_en       = 1'b0;
        track_count    = '0;

        tbl_req         = '0;
        tbl_req.bucket  = bucket_reg;
        tbl_req.way     = way_reg;
        tbl_req.key     = key_reg;

        // the output register empties as the sink takes it
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    key_next   = s_tdata[KEY_W-1:0];
                    hash_start = 1'b1;
                    state_next = ST_HASH;
                end
            end

            ST_HASH:
            begin
                if (hash_done)
                begin
                    bucket_next = hash_bucket;
                    state_next  = ST_FILL;
                end
            end

            ST_FILL:
            begin
                tbl_req.rd_fill = 1'b1;
                state_next      = ST_LOOK;
            end

            ST_LOOK:
            begin
                fill_next = tbl_fill;
                way_next  = '0;
                hit_next  = 1'b0;
                // empty bucket: straight to insert
                if (tbl_fill == '0)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                tbl_req.rd_slot = 1'b1;
                state_next      = ST_CMP;
            end

            ST_CMP:
            begin
                if (tbl_key == key_reg)
                begin
                    hit_next   = 1'b1;
                    cnt_next   = tbl_count;
                    state_next = ST_UPDATE;
                end
                else if ((FILL_W'(way_reg) + 1'b1) == fill_reg)
                begin
                    state_next = ST_UPDATE;
                end
                else
                begin
                    way_next   = way_reg + 1'b1;
                    state_next = ST_READ;
                end
            end

            ST_UPDATE:
            begin
                dropped_next = 1'b0;
                if (hit_reg)
                begin
                    // saturated slot stays as it is
                    if (cnt_reg != COUNT_MAX)
                    begin
                        tbl_req.wr_slot = 1'b1;
                        tbl_req.count   = cnt_reg + 1'b1;
                        track_en        = 1'b1;
                        track_count     = cnt_reg + 1'b1;
                    end
                end
                else if (fill_reg < FILL_W'(WAYS))
                begin
                    // insert in the first free way
                    tbl_req.wr_slot = 1'b1;
                    tbl_req.way     = fill_reg[WAY_AW-1:0];
                    tbl_req.count   = COUNT_W'(1);
                    tbl_req.wr_fill = 1'b1;
                    tbl_req.fill    = fill_reg + 1'b1;
                    track_en        = 1'b1;
                    track_count     = COUNT_W'(1);
                end
                else
                begin
                    dropped_next = 1'b1;
                end
                state_next = ST_OUT;
            end

            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {best_ties_reg, best_count_reg, best_key_reg};
                    out_drop_next  = dropped_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // top tracker: new leader, or one more key tied at the top (smaller key kept)
    always_comb
    begin
        best_key_next   = best_key_reg;
        best_count_next = best_count_reg;
        best_ties_next  = best_ties_reg;
        if (track_en)
        begin
            if (track_count > best_count_reg)
            begin
                best_count_next = track_count;
                best_key_next   = key_reg;
                best_ties_next  = TIES_W'(1);
            end
            else if (track_count == best_count_reg)
            begin
                if (best_ties_reg != TIES_MAX)
                begin
                    best_ties_next = best_ties_reg + 1'b1;
                end
                if (key_reg < best_key_reg)
                begin
                    best_key_next = key_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            best_key_reg   <= '0;
            best_count_reg <= '0;
            best_ties_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            best_key_reg   <= best_key_next;
            best_count_reg <= best_count_next;
            best_ties_reg  <= best_ties_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        bucket_reg   <= bucket_next;
        fill_reg     <= fill_next;
        way_reg      <= way_next;
        hit_reg      <= hit_next;
        cnt_reg      <= cnt_next;
        dropped_reg  <= dropped_next;
        out_data_reg <= out_data_next;
        out_drop_reg <= out_drop_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_drop_reg;

endmodule

// ===== rtl/kfc_hash.sv =====
// ----------------------------------------------------------------------------
// kfc_hash
// bucket hash in three steps: reciprocal multiply, back multiply and
// subtract, one correcting subtract
// ----------------------------------------------------------------------------
module kfc_hash
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [kfc_pkg::KEY_W-1:0]     key,
    output logic                          done,
    output logic [kfc_pkg::BUCKET_AW-1:0] bucket
);
    import kfc_pkg::*;

    localparam logic [HI_W-1:0]  RECIP_C = HI_W'(RECIP);
    localparam logic [HI_W-1:0]  ODD_C   = HI_W'(ODD_MOD);
    localparam logic [ODD_W-1:0] ODD_R   = ODD_W'(ODD_MOD);

    // one-hot step: quotient estimate, remainder, correction
    logic [2:0]           stage_reg, stage_next;
    logic                 done_reg,  done_next;
    logic [HI_W-1:0]      hi_reg,    hi_next;
    logic [LOW_SHIFT-1:0] low_reg,   low_next;
    logic [QUOT_W-1:0]    quot_reg,  quot_next;
    logic [ODD_W-1:0]     rem_reg,   rem_next;

    logic [2*HI_W-1:0]        prod;
    logic [HI_W-1:0]          back;
    logic [ODD_W+LOW_SHIFT-1:0] digits;

    // quotient estimate is the true one or one short
    assign prod   = {{HI_W{1'b0}}, hi_reg} * {{HI_W{1'b0}}, RECIP_C};
    assign back   = hi_reg - HI_W'(quot_reg) * ODD_C;
    assign digits = {rem_reg, low_reg};

    always_comb
    begin
        stage_next = {stage_reg[1:0], start};
        done_next  = stage_reg[2];
        hi_next    = hi_reg;
        low_next   = low_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        if (start)
        begin
            hi_next  = key[KEY_W-1:LOW_SHIFT];
            low_next = key[LOW_SHIFT-1:0];
        end
        if (stage_reg[0])
        begin
            quot_next = prod[QUOT_SHIFT +: QUOT_W];
        end
        if (stage_reg[1])
        begin
            // below twice the odd modulus
            rem_next = back[ODD_W-1:0];
        end
        if (stage_reg[2] && (rem_reg >= ODD_R))
        begin
            rem_next = rem_reg - ODD_R;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg   <= hi_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done   = done_reg;
    assign bucket = digits[BUCKET_AW-1:0];

endmodule

// ===== rtl/kfc_table.sv =====
// ----------------------------------------------------------------------------
// kfc_table
// slot memory, per-bucket fill counts and bucket valid flags
// ----------------------------------------------------------------------------
module kfc_table
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  kfc_pkg::kfc_tbl_req_t       req,
    output logic [kfc_pkg::KEY_W-1:0]   slot_key,
    output logic [kfc_pkg::COUNT_W-1:0] slot_count,
    output logic [kfc_pkg::FILL_W-1:0]  fill
);
    import kfc_pkg::*;

    kfc_slot_t         slot_mem [SLOTS];
    logic [FILL_W-1:0] fill_mem [BUCKETS];

    logic [BUCKETS-1:0] row_valid_reg;
    logic               row_hit_reg;
    logic [FILL_W-1:0]  fill_rd_reg;
    kfc_slot_t          slot_rd_reg;
    logic [SLOT_AW-1:0] slot_addr;

    assign slot_addr = SLOT_AW'(req.bucket) * SLOT_AW'(WAYS) + SLOT_AW'(req.way);

    // a bucket never written since reset reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (req.wr_fill)
        begin
            row_valid_reg[req.bucket] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_fill)
        begin
            fill_rd_reg <= fill_mem[req.bucket];
            row_hit_reg <= row_valid_reg[req.bucket];
        end
        if (req.wr_fill)
        begin
            fill_mem[req.bucket] <= req.fill;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_slot)
        begin
            slot_rd_reg <= slot_mem[slot_addr];
        end
        if (req.wr_slot)
        begin
            slot_mem[slot_addr] <= '{key: req.key, count: req.count};
        end
    end

    assign fill       = row_hit_reg ? fill_rd_reg : '0;
    assign slot_key   = slot_rd_reg.key;
    assign slot_count = slot_rd_reg.count;

endmodule
